[hdl/radix_digit_converter_defines.svh]
// assertion macros for the radix digit converter
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rdc_pkg.sv]
// types, constants and microcode program of the radix digit converter
`default_nettype none

package rdc_pkg;

  localparam int VALUE_BITS      = 32;
  localparam int BASE_BITS       = 5;
  localparam int DIGIT_BITS      = 4;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_MAX_DIGITS  = 32;

  localparam logic [BASE_BITS-1:0] BASE_MIN = BASE_BITS'(2);
  localparam logic [BASE_BITS-1:0] BASE_MAX = BASE_BITS'(16);

  localparam int STEP_BITS = 3;
  typedef logic [STEP_BITS-1:0] step_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_BITS-1:0]  base;
  } req_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit;
    logic                  is_last;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_START,
    OP_STORE,
    OP_READ,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_REQ,
    CND_DIV_BUSY,
    CND_MORE_DIV,
    CND_RSP_FULL,
    CND_DIGITS_LEFT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic req_valid;
    logic div_busy;
    logic more_div;
    logic rsp_full;
    logic digits_left;
  } status_t;

  localparam step_t S_WAIT     = 3'd0;
  localparam step_t S_DIV      = 3'd1;
  localparam step_t S_DIV_WAIT = 3'd2;
  localparam step_t S_STORE    = 3'd3;
  localparam step_t S_READ     = 3'd4;
  localparam step_t S_EMIT     = 3'd5;
  localparam step_t S_LOOP     = 3'd6;
  localparam step_t S_DONE     = 3'd7;

  // control store: jump to target when cond holds, else fall through
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      S_WAIT:     w = '{op: OP_ACCEPT,    cond: CND_NO_REQ,      target: S_WAIT};
      S_DIV:      w = '{op: OP_DIV_START, cond: CND_NEVER,       target: S_WAIT};
      S_DIV_WAIT: w = '{op: OP_NOP,       cond: CND_DIV_BUSY,    target: S_DIV_WAIT};
      S_STORE:    w = '{op: OP_STORE,     cond: CND_MORE_DIV,    target: S_DIV};
      S_READ:     w = '{op: OP_READ,      cond: CND_NEVER,       target: S_WAIT};
      S_EMIT:     w = '{op: OP_EMIT,      cond: CND_RSP_FULL,    target: S_EMIT};
      S_LOOP:     w = '{op: OP_NOP,       cond: CND_DIGITS_LEFT, target: S_READ};
      S_DONE:     w = '{op: OP_NOP,       cond: CND_ALWAYS,      target: S_WAIT};
      default:    w = '{op: OP_NOP,       cond: CND_ALWAYS,      target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/rdc_divider.sv]
// restoring divider, one quotient bit per cycle, small divisor
`default_nettype none

module rdc_divider #(
  parameter int VALUE_WIDTH = rdc_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [VALUE_WIDTH-1:0]         dividend,
  input  wire logic [rdc_pkg::BASE_BITS-1:0]  divisor,
  output logic                                busy,
  output logic [VALUE_WIDTH-1:0]              quot,
  output logic [rdc_pkg::DIGIT_BITS-1:0]      rem
);
  import rdc_pkg::*;

  localparam int CNT_BITS = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] q;
  logic [BASE_BITS-1:0]   r;
  logic [BASE_BITS-1:0]   d;
  logic [CNT_BITS-1:0]    cnt;
  logic [BASE_BITS-1:0]   r_shift;
  logic                   fits;

  assign r_shift = {r[BASE_BITS-2:0], q[VALUE_WIDTH-1]};
  assign fits    = (r_shift >= d);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(VALUE_WIDTH);
    end else if (busy) begin
      cnt  <= cnt - CNT_BITS'(1);
      busy <= (cnt != CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= {q[VALUE_WIDTH-2:0], fits};
      r <= fits ? (r_shift - d) : r_shift;
    end
  end

  assign quot = q;
  assign rem  = r[DIGIT_BITS-1:0];

endmodule

`default_nettype wire

[hdl/rdc_digit_mem.sv]
// digit store, one write port and one registered read port
`default_nettype none

module rdc_digit_mem #(
  parameter  int DEPTH     = rdc_pkg::DEF_MAX_DIGITS,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [ADDR_BITS-1:0]          waddr,
  input  wire logic [rdc_pkg::DIGIT_BITS-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [ADDR_BITS-1:0]          raddr,
  output logic [rdc_pkg::DIGIT_BITS-1:0]     rdata
);
  import rdc_pkg::*;

  logic [DIGIT_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/rdc_sequencer.sv]
// microcode step counter with conditional jumps
`default_nettype none

module rdc_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rdc_pkg::status_t status,
  output rdc_pkg::op_t          op
);
  import rdc_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   jump;

  assign uw = ucode(step);
  assign op = uw.op;

  always_comb begin
    case (uw.cond)
      CND_NEVER:       jump = 1'b0;
      CND_ALWAYS:      jump = 1'b1;
      CND_NO_REQ:      jump = !status.req_valid;
      CND_DIV_BUSY:    jump = status.div_busy;
      CND_MORE_DIV:    jump = status.more_div;
      CND_RSP_FULL:    jump = status.rsp_full;
      CND_DIGITS_LEFT: jump = status.digits_left;
      default:         jump = 1'b0;
    endcase
    step_next = jump ? uw.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

[hdl/radix_digit_converter.sv]
// radix digit converter top level: datapath around a microcoded sequencer
//
// req channel (req_valid/req_ready, payload req): one unsigned value and a
// base; bases below 2 act as 2, above 16 act as 16. rsp channel
// (rsp_valid/rsp_ready, payload rsp): the digits, most significant first,
// is_last set on the least significant one. zero gives the single digit 0;
// a value needing more than MAX_DIGITS digits yields its low MAX_DIGITS.
// each digit costs the div, div-wait and store steps, with one pass of the
// bit-serial divider in div-wait; the read, emit and loop steps give it out.
// one item is worked at a time; req_ready is high only while waiting.
// the rsp register lets the last digit wait while the next item transfers in.
// a stalled receiver holds the sequencer on its emit step; nothing is lost.
// synchronous reset returns to waiting with no digit pending.
`default_nettype none

module radix_digit_converter #(
  parameter int VALUE_WIDTH = rdc_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_DIGITS  = rdc_pkg::DEF_MAX_DIGITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire rdc_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rdc_pkg::rsp_t      rsp
);
  import rdc_pkg::*;

  `include "radix_digit_converter_defines.svh"

  localparam int CNT_BITS  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_BITS = $clog2(MAX_DIGITS);

  op_t                    op;
  status_t                status;
  logic [VALUE_WIDTH-1:0] value;
  logic [BASE_BITS-1:0]   base;
  logic [BASE_BITS-1:0]   base_next;
  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    count_dec;
  logic [VALUE_WIDTH+VALUE_BITS-1:0] value_ext;
  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] quot;
  logic [DIGIT_BITS-1:0]  rem;
  logic [DIGIT_BITS-1:0]  rdata;
  logic                   accept;
  logic                   store;
  logic                   emit;
  logic                   rsp_full;

  assign value_ext = {{VALUE_WIDTH{1'b0}}, req.value};
  assign count_dec = count - CNT_BITS'(1);

  always_comb begin
    if (req.base < BASE_MIN) begin
      base_next = BASE_MIN;
    end else if (req.base > BASE_MAX) begin
      base_next = BASE_MAX;
    end else begin
      base_next = req.base;
    end
  end

  assign req_ready = (op == OP_ACCEPT) && !rst;
  assign accept    = req_valid && req_ready;
  assign store     = (op == OP_STORE);
  assign rsp_full  = rsp_valid && !rsp_ready;
  assign emit      = (op == OP_EMIT) && !rsp_full;

  assign status.req_valid   = req_valid;
  assign status.div_busy    = div_busy;
  assign status.more_div    = (quot != '0) && (count != CNT_BITS'(MAX_DIGITS - 1));
  assign status.rsp_full    = rsp_full;
  assign status.digits_left = (count != '0);

  rdc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  rdc_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (op == OP_DIV_START),
    .dividend (value),
    .divisor  (base),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  rdc_digit_mem #(
    .DEPTH (MAX_DIGITS)
  ) u_mem (
    .clk   (clk),
    .we    (store),
    .waddr (count[ADDR_BITS-1:0]),
    .wdata (rem),
    .re    (op == OP_READ),
    .raddr (count_dec[ADDR_BITS-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      value <= value_ext[VALUE_WIDTH-1:0];
      base  <= base_next;
    end else if (store) begin
      value <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= '0;
    end else if (store) begin
      count <= count + CNT_BITS'(1);
    end else if (emit) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.digit   <= rdata;
      rsp.is_last <= (count == CNT_BITS'(1));
    end
  end

  `RDC_ASSERT_NOW(a_idle_clean, req_ready, (count == '0) && !div_busy, "busy while waiting for req")
  `RDC_ASSERT_NOW(a_store_in_range, store, count < CNT_BITS'(MAX_DIGITS), "digit store overflow")
  `RDC_ASSERT_NOW(a_emit_has_digit, op == OP_EMIT, count != '0, "emit with no digit left")
  `RDC_ASSERT_NEXT(a_last_flag, emit, rsp.is_last == (count == '0), "is_last out of step with count")

endmodule

`default_nettype wire

[tb/sv/tb_radix_digit_converter.sv]
// testbench for radix_digit_converter: directed table and random values, checked digit by digit
`timescale 1ns / 1ps

module tb_radix_digit_converter;
  import rdc_pkg::*;

  localparam int RANDOM_ITEMS = 385;
  localparam int HOLD_OFF_AFTER = 60;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 1300;
  localparam int LIMIT_CYCLES = 4000000;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_BITS-1:0] base;
    logic known;
    logic [5:0] known_count;
    logic [4*DEF_MAX_DIGITS-1:0] known_digits;
  } conv_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic [DIGIT_BITS-1:0] digit_store [DEF_MAX_DIGITS];
  logic [5:0] digit_count = '0;
  rsp_t digits_due [$];
  rsp_t due_digit;
  int errors = 0;
  int transfers_in = 0;
  int burst_left = 0;
  int cycle_count = 0;

  // digits are nibbles, least significant at the bottom
  conv_row_t directed_rows [25] = '{
    '{32'd0,          5'd10, 1'b1, 6'd1,  128'h0},
    '{32'd0,          5'd0,  1'b1, 6'd1,  128'h0},
    '{32'd0,          5'd31, 1'b1, 6'd1,  128'h0},
    '{32'd1,          5'd2,  1'b1, 6'd1,  128'h1},
    '{32'hFFFFFFFF,   5'd2,  1'b1, 6'd32, 128'h11111111_11111111_11111111_11111111},
    '{32'hFFFFFFFF,   5'd0,  1'b1, 6'd32, 128'h11111111_11111111_11111111_11111111},
    '{32'hFFFFFFFF,   5'd1,  1'b1, 6'd32, 128'h11111111_11111111_11111111_11111111},
    '{32'hFFFFFFFF,   5'd16, 1'b1, 6'd8,  128'hFFFFFFFF},
    '{32'hFFFFFFFF,   5'd17, 1'b1, 6'd8,  128'hFFFFFFFF},
    '{32'hFFFFFFFF,   5'd31, 1'b1, 6'd8,  128'hFFFFFFFF},
    '{32'h80000000,   5'd2,  1'b1, 6'd32, 128'h10000000_00000000_00000000_00000000},
    '{32'd15,         5'd16, 1'b1, 6'd1,  128'hF},
    '{32'd16,         5'd16, 1'b1, 6'd2,  128'h10},
    '{32'd9,          5'd10, 1'b1, 6'd1,  128'h9},
    '{32'd10,         5'd10, 1'b1, 6'd2,  128'h10},
    '{32'd4294967295, 5'd10, 1'b1, 6'd10, 128'h4294967295},
    '{32'h12345678,   5'd16, 1'b1, 6'd8,  128'h12345678},
    '{32'hFFFFFFFF,   5'd3,  1'b0, 6'd0,  128'h0},
    '{32'h55555555,   5'd4,  1'b0, 6'd0,  128'h0},
    '{32'hDEADBEEF,   5'd7,  1'b0, 6'd0,  128'h0},
    '{32'd1000000,    5'd13, 1'b0, 6'd0,  128'h0},
    '{32'h7FFFFFFF,   5'd15, 1'b0, 6'd0,  128'h0},
    '{32'hAAAAAAAA,   5'd5,  1'b0, 6'd0,  128'h0},
    '{32'd255,        5'd9,  1'b0, 6'd0,  128'h0},
    '{32'd1,          5'd31, 1'b0, 6'd0,  128'h0}
  };

  radix_digit_converter dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // repeated division, remainders stored least significant first
  function automatic void convert_to_digits(input logic [VALUE_BITS-1:0] value,
                                            input logic [BASE_BITS-1:0] base);
    logic [VALUE_BITS-1:0] rest;
    logic [BASE_BITS-1:0] radix;
    int n;
    radix = base;
    if (radix < BASE_MIN) radix = BASE_MIN;
    else if (radix > BASE_MAX) radix = BASE_MAX;
    rest = value;
    n = 0;
    if (rest == '0) begin
      digit_store[0] = '0;
      n = 1;
    end else begin
      while (rest != '0 && n < DEF_MAX_DIGITS) begin
        digit_store[n] = DIGIT_BITS'(rest % radix);
        rest = rest / radix;
        n++;
      end
    end
    digit_count = 6'(n);
  endfunction

  // offer one item at a falling edge, hold it until the transfer, then idle at random
  task automatic send_row(input conv_row_t row);
    int n;
    int idx;
    int gap;
    req_valid <= 1'b1;
    req <= '{value: row.value, base: row.base};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    convert_to_digits(row.value, row.base);
    n = row.known ? int'(row.known_count) : int'(digit_count);
    for (int k = 0; k < n; k++) begin
      idx = n - 1 - k;
      digits_due.push_back('{digit: row.known ? row.known_digits[idx*4 +: 4] : digit_store[idx],
                             is_last: (idx == 0)});
    end
    transfers_in++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 15);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (digits_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected digit %h is_last %b", $time, rsp.digit, rsp.is_last);
      end else begin
        due_digit = digits_due.pop_front();
        if (rsp.digit !== due_digit.digit) begin
          errors++;
          $display("%0t: digit expected %h got %h", $time, due_digit.digit, rsp.digit);
        end
        if (rsp.is_last !== due_digit.is_last) begin
          errors++;
          $display("%0t: is_last expected %b got %b", $time, due_digit.is_last, rsp.is_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_radix_digit_converter NOT OK");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off so the block backs up
  initial begin
    int sink_mode;
    int sink_left;
    bit held_off;
    sink_mode = 0;
    sink_left = 0;
    held_off = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held_off && transfers_in >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (sink_left == 0) begin
          sink_mode = $urandom_range(0, 3);
          sink_left = $urandom_range(20, 300);
        end
        sink_left--;
        case (sink_mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ready <= ($urandom_range(0, 1) != 0);
          default: rsp_ready <= (sink_left % 16 >= 10);
        endcase
      end
    end
  end

  initial begin
    conv_row_t row;
    int bits;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) send_row(directed_rows[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      bits = $urandom_range(0, VALUE_BITS);
      row = '0;
      row.value = (bits == 0) ? '0 : ($urandom() >> (VALUE_BITS - bits));
      row.base = ($urandom_range(0, 6) == 0) ? BASE_BITS'($urandom_range(0, 31))
                                             : BASE_BITS'($urandom_range(2, 16));
      send_row(row);
    end
    req_valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_radix_digit_converter OK");
    end else begin
      $display("tb_radix_digit_converter NOT OK");
    end
    $finish;
  end

endmodule
